// File: sv/zci_pkg.sv
// Shared types and constants of the zero-crossing interpolator.
package zci_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int KIND_W   = 2;
  localparam int POS_W    = 24;
  localparam int FRAC_W   = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRST = 2'd0,
    KIND_FALL  = 2'd1,
    KIND_RISE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] num;
    logic [MAG_W-1:0] den;
  } div_req_t;

endpackage

// File: sv/zci_if.sv
// Valid/ready channels for input samples and crossing events.
interface zci_sample_if;
  import zci_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       block_start;

  modport source (output valid, sample, block_start, input ready);
  modport sink (input valid, sample, block_start, output ready);
endinterface

interface zci_event_if;
  import zci_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] crossing_kind;
  logic [POS_W-1:0]  sample_position;
  logic [FRAC_W-1:0] crossing_fraction;

  modport source (output valid, crossing_kind, sample_position, crossing_fraction,
                  input ready);
  modport sink (input valid, crossing_kind, sample_position, crossing_fraction,
                output ready);
endinterface

// File: sv/zci_div.sv
// Restoring divider, one quotient bit per cycle, for the crossing fraction.
module zci_div
  import zci_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  div_req_t             req,
  output logic                 done,
  output logic [FRAC_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] den;
  logic [MAG_W:0]   shifted;
  logic [MAG_W:0]   diff;
  logic             take;

  // Remainder stays below the divisor, so the doubled value fits one extra bit.
  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, den};
  assign take    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      cnt  <= CNT_W'(FRAC_BITS);
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      den <= req.den;
    end else if (cnt != '0) begin
      rem      <= take ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
      quotient <= {quotient[FRAC_BITS-2:0], take};
    end
  end

endmodule

// File: sv/zero_crossing_interpolator_core.sv
// Zero-crossing detector with interpolated crossing position.
// An accepted sample that causes no event leaves the block ready again in the next
// cycle. A crossing with both neighbor samples nonzero runs the serial divider, one
// quotient bit per step, and then enters the hold state before the next sample is
// taken; a crossing onto or off an exact zero goes straight to the hold state. The
// event sits in an output register, so the next sample is accepted while it waits
// to be taken; a later crossing that finds that register still full holds the input
// until the waiting event is taken. A start word resets detection and the sample
// count and gives no event; sample_position saturates with the count.
module zero_crossing_interpolator_core
  import zci_pkg::*;
#(
  parameter int INDEX_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic  clk,
  input  logic  rst,
  zci_sample_if.sink   samples,
  zci_event_if.source  events
);

  state_t                     state;
  state_t                     state_next;
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic [INDEX_BITS-1:0]      index;
  logic                       first_found;
  logic                       pol_pos;
  kind_t                      ev_kind;
  logic [POS_W-1:0]           ev_pos;
  logic                       ev_frac_zero;
  logic                       out_valid;
  kind_t                      out_kind;
  logic [POS_W-1:0]           out_pos;
  logic [FRAC_W-1:0]          out_frac;

  logic                  accept;
  logic                  y_neg;
  logic                  y_zero;
  logic                  y0_neg;
  logic                  y0_zero;
  logic [INDEX_BITS-1:0] index_next;
  logic                  hit_first;
  logic                  hit_fall;
  logic                  hit_rise;
  logic                  hit;
  kind_t                 hit_kind;
  logic [MAG_W-1:0]      mag_y;
  logic [MAG_W-1:0]      mag_y0;
  logic                  out_free;
  div_req_t              div_req;
  logic                  div_done;
  logic [FRAC_BITS-1:0]  quotient;

  assign accept   = samples.valid && samples.ready;
  assign out_free = !out_valid || events.ready;

  assign y_neg   = samples.sample[SAMPLE_W-1];
  assign y_zero  = (samples.sample == '0);
  assign y0_neg  = prev_sample[SAMPLE_W-1];
  assign y0_zero = (prev_sample == '0);

  // Hold the count at its top value once reached.
  assign index_next = (index == '1) ? index : index + INDEX_BITS'(1);

  assign hit_first = !first_found && y0_neg && !y_neg;
  assign hit_fall  = first_found && pol_pos && y_neg;
  assign hit_rise  = first_found && !pol_pos && !y_neg && !y_zero;
  assign hit       = !samples.block_start && (hit_first || hit_fall || hit_rise);

  always_comb begin
    if (hit_first) begin
      hit_kind = KIND_FIRST;
    end else if (hit_fall) begin
      hit_kind = KIND_FALL;
    end else begin
      hit_kind = KIND_RISE;
    end
  end

  assign mag_y  = y_neg ? (MAG_W'(0) - {samples.sample[SAMPLE_W-1], samples.sample})
                        : {1'b0, samples.sample};
  assign mag_y0 = y0_neg ? (MAG_W'(0) - {prev_sample[SAMPLE_W-1], prev_sample})
                         : {1'b0, prev_sample};

  assign div_req.start = accept && hit && !y_zero && !y0_zero;
  assign div_req.num   = mag_y0;
  assign div_req.den   = mag_y0 + mag_y;

  zci_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && hit) begin
          state_next = (y_zero || y0_zero) ? ST_HOLD : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    samples.ready            = 1'b0;
    case (state)
      ST_IDLE:   samples.ready = 1'b1;
      ST_DIVIDE: samples.ready = 1'b0;
      ST_HOLD:   samples.ready = 1'b0;
      default:   samples.ready = 1'b0;
    endcase
    events.valid             = out_valid;
    events.crossing_kind     = out_kind;
    events.sample_position   = out_pos;
    events.crossing_fraction = out_frac;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      prev_sample <= '0;
      index       <= '0;
      first_found <= 1'b0;
      pol_pos     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        prev_sample <= samples.sample;
        if (samples.block_start) begin
          index       <= '0;
          first_found <= 1'b0;
          pol_pos     <= 1'b0;
        end else begin
          index <= index_next;
          if (hit) begin
            first_found <= 1'b1;
            pol_pos     <= hit_first || hit_rise;
          end
        end
      end
      if (state == ST_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hit) begin
      ev_kind      <= hit_kind;
      ev_pos       <= y_zero ? POS_W'(index_next) : POS_W'(index_next - INDEX_BITS'(1));
      ev_frac_zero <= y_zero || y0_zero;
    end
    if (state == ST_HOLD && out_free) begin
      out_kind <= ev_kind;
      out_pos  <= ev_pos;
      out_frac <= ev_frac_zero ? '0 : FRAC_W'(quotient);
    end
  end

`ifndef SYNTHESIS
  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide state");

  a_quiet_sample: assert property (@(posedge clk) disable iff (rst)
    (accept && !hit) |=> state == ST_IDLE)
    else $error("sample without a crossing left the block busy");

  a_polarity_order: assert property (@(posedge clk) disable iff (rst)
    !first_found |-> !pol_pos)
    else $error("polarity set before the first rising crossing");
`endif

endmodule

// File: tb/zero_crossing_interpolator_core_tb.sv
// Self-checking testbench for the zero-crossing interpolator core.
module zero_crossing_interpolator_core_tb;
  import zci_pkg::*;

  localparam int INDEX_BITS  = 24;
  localparam int FRAC_BITS   = 16;
  localparam int TOTAL_WORDS = 525;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = FRAC_BITS + 8;
  localparam int CYCLE_LIMIT = 200000;

  // Idling phases, chosen by the number of accepted sample words.
  localparam int PH_STEADY      = 0;
  localparam int PH_SEND_GAPS   = 1;
  localparam int PH_RECV_STALLS = 2;
  localparam int PH_BOTH        = 3;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start;
  } sample_word_t;

  typedef struct {
    kind_t             kind;
    logic [POS_W-1:0]  pos;
    logic [FRAC_W-1:0] frac;
  } crossing_t;

  logic clk;
  logic rst;

  zci_sample_if sample_ch ();
  zci_event_if  event_ch ();

  zero_crossing_interpolator_core #(
    .INDEX_BITS (INDEX_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .events  (event_ch)
  );

  sample_word_t pending_words[$];
  crossing_t    crossing_q[$];

  // Predictor state.
  logic signed [SAMPLE_W-1:0] last_sample;
  logic [INDEX_BITS-1:0]      last_index;
  logic                       rise_seen;
  logic                       above_zero;

  int errors;
  int accepted_cnt;
  int hold_left;
  bit hold_done;
  int cycle_cnt;
  int phase;

  assign phase = (accepted_cnt < 150) ? PH_STEADY :
                 (accepted_cnt < 280) ? PH_SEND_GAPS :
                 (accepted_cnt < 410) ? PH_RECV_STALLS : PH_BOTH;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Advance the detector by one word and queue the crossing it reports, if any.
  task automatic predict_crossing(input logic signed [SAMPLE_W-1:0] y, input logic start);
    crossing_t c;
    int        y0;
    int        yc;
    longint    a;
    longint    d;
    bit        hit;
    y0  = last_sample;
    yc  = y;
    hit = 1'b0;
    if (start) begin
      last_index = '0;
      rise_seen  = 1'b0;
      above_zero = 1'b0;
    end else begin
      if (last_index != {INDEX_BITS{1'b1}}) last_index = last_index + 1'b1;
      if (!rise_seen) begin
        if (y0 < 0 && yc >= 0) begin
          c.kind     = KIND_FIRST;
          hit        = 1'b1;
          rise_seen  = 1'b1;
          above_zero = 1'b1;
        end
      end else if (above_zero) begin
        if (yc < 0) begin
          c.kind     = KIND_FALL;
          hit        = 1'b1;
          above_zero = 1'b0;
        end
      end else if (yc > 0) begin
        c.kind     = KIND_RISE;
        hit        = 1'b1;
        above_zero = 1'b1;
      end
      if (hit) begin
        c.frac = '0;
        if (yc == 0) begin
          c.pos = POS_W'(last_index);
        end else begin
          c.pos = POS_W'(last_index - 1'b1);
          if (y0 != 0) begin
            a = (y0 < 0) ? -y0 : y0;
            d = a + ((yc < 0) ? -yc : yc);
            c.frac = FRAC_W'((a << FRAC_BITS) / d);
          end
        end
        crossing_q.push_back(c);
      end
    end
    last_sample = y;
  endtask

  task automatic add_word(input int value, input logic start);
    sample_word_t w;
    w.sample = value[SAMPLE_W-1:0];
    w.start  = start;
    pending_words.push_back(w);
  endtask

  // Sample driver.
  always @(posedge clk) begin
    sample_word_t w;
    bit idle;
    if (rst) begin
      sample_ch.valid <= 1'b0;
      accepted_cnt    <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        predict_crossing(sample_ch.sample, sample_ch.block_start);
        accepted_cnt <= accepted_cnt + 1;
      end
      idle = 1'b0;
      if (phase == PH_SEND_GAPS) idle = $urandom_range(0, 99) < 48;
      else if (phase == PH_BOTH) idle = $urandom_range(0, 99) < 10;
      if (!sample_ch.valid || sample_ch.ready) begin
        if (pending_words.size() != 0 && !idle) begin
          w = pending_words.pop_front();
          sample_ch.valid       <= 1'b1;
          sample_ch.sample      <= w.sample;
          sample_ch.block_start <= w.start;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off so the block fills up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Event monitor.
  always @(posedge clk) begin
    crossing_t exp_c;
    bit stall;
    if (rst) begin
      event_ch.ready <= 1'b0;
    end else begin
      if (event_ch.valid && event_ch.ready) begin
        if (crossing_q.size() == 0) begin
          $display("%0t: unexpected event kind %0d pos %0d frac %0d", $time,
                   event_ch.crossing_kind, event_ch.sample_position,
                   event_ch.crossing_fraction);
          errors++;
        end else begin
          exp_c = crossing_q.pop_front();
          if (event_ch.crossing_kind !== exp_c.kind ||
              event_ch.sample_position !== exp_c.pos ||
              event_ch.crossing_fraction !== exp_c.frac) begin
            $display({"%0t: mismatch expected kind %0d pos %0d frac %0d,",
                      " actual kind %0d pos %0d frac %0d"},
                     $time, exp_c.kind, exp_c.pos, exp_c.frac, event_ch.crossing_kind,
                     event_ch.sample_position, event_ch.crossing_fraction);
            errors++;
          end
        end
      end
      stall = 1'b0;
      if (phase == PH_RECV_STALLS) stall = $urandom_range(0, 99) < 48;
      else if (phase == PH_BOTH) stall = $urandom_range(0, 99) < 10;
      event_ch.ready <= (hold_left == 0) && !stall;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int len;
    int mode;
    int run;
    int v;
    bit neg;
    errors    = 0;
    cycle_cnt = 0;
    last_sample = '0;
    last_index  = '0;
    rise_seen   = 1'b0;
    above_zero  = 1'b0;
    rst = 1'b1;
    sample_ch.valid       = 1'b0;
    sample_ch.sample      = '0;
    sample_ch.block_start = 1'b0;
    event_ch.ready        = 1'b0;

    // Directed: detection straight out of reset, then buffers at the sample extremes,
    // crossings onto and off exact zero, and restarts in the middle of detection.
    add_word(-100, 1'b0);
    add_word(50, 1'b0);
    add_word(-32768, 1'b0);
    add_word(32767, 1'b0);
    add_word(0, 1'b1);
    add_word(-1, 1'b0);
    add_word(0, 1'b0);
    add_word(-32768, 1'b0);
    add_word(0, 1'b0);
    add_word(1, 1'b0);
    add_word(-1, 1'b0);
    add_word(32767, 1'b0);
    add_word(-32768, 1'b1);
    add_word(32767, 1'b0);
    add_word(32767, 1'b1);
    add_word(-32768, 1'b0);
    add_word(-32768, 1'b0);
    add_word(1, 1'b0);
    add_word(-32768, 1'b0);
    add_word(-1, 1'b0);
    add_word(32767, 1'b0);
    add_word(-1, 1'b1);
    add_word(0, 1'b0);
    add_word(-2, 1'b0);

    // Random buffers: mostly oscillating waveforms, some near zero, some noise.
    while (pending_words.size() < TOTAL_WORDS) begin
      mode = $urandom_range(0, 7);
      len  = $urandom_range(4, 40);
      if ($urandom_range(0, 5) != 0) add_word($urandom_range(0, 65535), 1'b1);
      neg = $urandom_range(0, 1);
      run = 0;
      for (int k = 0; k < len; k++) begin
        if (mode == 0) begin
          add_word($urandom_range(0, 65535), $urandom_range(0, 7) == 0);
        end else if (mode <= 2) begin
          v = int'($urandom_range(0, 6)) - 3;
          add_word(v, 1'b0);
        end else begin
          // Flip sign every few words; drop in an exact zero now and then.
          if (run == 0) begin
            neg = ~neg;
            run = $urandom_range(1, 3);
          end
          run--;
          if ($urandom_range(0, 7) == 0) v = 0;
          else if (neg) v = -$urandom_range(1, 32768);
          else v = $urandom_range(1, 32767);
          add_word(v, 1'b0);
        end
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || accepted_cnt < TOTAL_WORDS) @(negedge clk);
    while (crossing_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (errors == 0 && crossing_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/zci_pkg.sv
sv/zci_if.sv
sv/zci_div.sv
sv/zero_crossing_interpolator_core.sv
tb/zero_crossing_interpolator_core_tb.sv
